// ===== design/au_header_and_sample_parser_top_defines.svh =====
// Assertion macros used by the checker file of the audio parser.
// Each macro places one labeled concurrent assertion on the i_clk domain.
`ifndef AU_HEADER_AND_SAMPLE_PARSER_TOP_DEFINES_SVH
`define AU_HEADER_AND_SAMPLE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define AU_HSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("au_hsp assertion failed");

// Next-cycle implication, also checked across reset.
`define AU_HSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("au_hsp assertion failed");

`endif

// ===== design/au_hsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package au_hsp_pkg;

    localparam int unsigned HEADER_BYTES = 24;
    localparam int unsigned WORD_BYTES   = 4;
    localparam int unsigned SAMPLE_BYTES = 2;
    localparam int unsigned HEADER_WORDS = HEADER_BYTES / WORD_BYTES;

    // Result status codes
    localparam logic [2:0] ST_HEADER_BYTE = 3'd0;
    localparam logic [2:0] ST_WORD_OK     = 3'd1;
    localparam logic [2:0] ST_SKIPPING    = 3'd2;
    localparam logic [2:0] ST_HEADER_DONE = 3'd3;
    localparam logic [2:0] ST_HALF_SAMPLE = 3'd4;
    localparam logic [2:0] ST_SAMPLE      = 3'd5;
    localparam logic [2:0] ST_ERROR       = 3'd6;

    // Header word numbers
    localparam logic [2:0] WD_MAGIC    = 3'd1;
    localparam logic [2:0] WD_OFFSET   = 3'd2;
    localparam logic [2:0] WD_SIZE     = 3'd3;
    localparam logic [2:0] WD_ENCODING = 3'd4;
    localparam logic [2:0] WD_RATE     = 3'd5;
    localparam logic [2:0] WD_CHANNELS = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAGIC      = 3'd0;
    localparam logic [2:0] CFG_MIN_OFFSET = 3'd1;
    localparam logic [2:0] CFG_ENCODING   = 3'd2;
    localparam logic [2:0] CFG_RATE       = 3'd3;
    localparam logic [2:0] CFG_CHANNELS   = 3'd4;

    localparam logic [31:0] RST_MAGIC      = 32'd779316836;
    localparam logic [31:0] RST_MIN_OFFSET = 32'd24;
    localparam logic [31:0] RST_ENCODING   = 32'd3;
    localparam logic [31:0] RST_RATE       = 32'd8000;
    localparam logic [31:0] RST_CHANNELS   = 32'd1;

    typedef logic [2:0]  t_status;
    typedef logic [2:0]  t_cfg_index;
    typedef logic [31:0] t_word;

endpackage

`default_nettype wire

// ===== design/au_header_and_sample_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial parser for a PCM16 audio file. Each accepted byte yields exactly one result
// item: six big-endian header words are gathered and checked against the configuration
// registers, annotation bytes up to the data offset are skipped, then byte pairs are
// joined high byte first into signed 16-bit samples. A failed check reports status 6 and
// keeps reporting it until a byte arrives with new_file set, which restarts parsing with
// that byte as the first of the file. Throughput is one byte per clock unless the sink
// stalls; the result of a byte appears in the cycle after it is accepted, from a single
// output register that lets the next byte in while a result waits if the sink takes it.
// Write the configuration registers only while no item is in flight.
module au_header_and_sample_parser_top (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  au_hsp_pkg::t_cfg_index   i_cfg_index,
    input  au_hsp_pkg::t_word        i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [7:0]               i_data_byte,
    input  wire                      i_new_file,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output au_hsp_pkg::t_status      o_status,
    output logic [2:0]               o_word_index,
    output au_hsp_pkg::t_word        o_word_value,
    output logic signed [15:0]       o_sample_value
);
    import au_hsp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    t_word r_cfg_magic, r_cfg_min_offset, r_cfg_encoding, r_cfg_rate, r_cfg_channels;

    logic [4:0]  r_byte_count, n_byte_count;
    t_word       r_word_accum, n_word_accum;
    t_word       r_skip, n_skip;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_high_byte, n_high_byte;
    logic        r_half, n_half;
    logic        r_err, n_err;

    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [2:0]  r_widx, n_widx;
    t_word       r_wval, n_wval;
    logic [15:0] r_samp, n_samp;

    logic        w_take;
    logic [4:0]  e_count;
    t_word       e_accum, e_skip;
    t_phase      e_phase;
    logic [7:0]  e_high;
    logic        e_half, e_err;
    logic [4:0]  w_cnt;
    t_word       w_acc;
    logic        w_ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        // A new file starts from cleared parse state.
        e_count = i_new_file ? '0 : r_byte_count;
        e_accum = i_new_file ? '0 : r_word_accum;
        e_skip  = i_new_file ? '0 : r_skip;
        e_phase = i_new_file ? PH_HEADER : r_phase;
        e_high  = i_new_file ? '0 : r_high_byte;
        e_half  = i_new_file ? 1'b0 : r_half;
        e_err   = i_new_file ? 1'b0 : r_err;

        n_byte_count = e_count;
        n_word_accum = e_accum;
        n_skip       = e_skip;
        n_phase      = e_phase;
        n_high_byte  = e_high;
        n_half       = e_half;
        n_err        = e_err;
        n_status     = ST_HEADER_BYTE;
        n_widx       = '0;
        n_wval       = '0;
        n_samp       = '0;
        w_cnt        = e_count + 5'd1;
        w_acc        = {e_accum[23:0], i_data_byte};
        w_ok         = 1'b0;

        if (e_err) begin
            n_status = ST_ERROR;
        end else begin
            case (e_phase)
                PH_HEADER: begin
                    n_byte_count = w_cnt;
                    n_word_accum = w_acc;
                    if (w_cnt[1:0] == 2'd0) begin
                        n_widx       = w_cnt[4:2];
                        n_wval       = w_acc;
                        n_word_accum = '0;
                        case (w_cnt[4:2])
                            WD_MAGIC:    w_ok = (w_acc == r_cfg_magic);
                            WD_OFFSET: begin
                                w_ok   = (w_acc >= r_cfg_min_offset);
                                n_skip = (w_acc > 32'(HEADER_BYTES))
                                       ? w_acc - 32'(HEADER_BYTES) : '0;
                            end
                            WD_SIZE:     w_ok = 1'b1;
                            WD_ENCODING: w_ok = (w_acc == r_cfg_encoding);
                            WD_RATE:     w_ok = (w_acc == r_cfg_rate);
                            WD_CHANNELS: w_ok = (w_acc == r_cfg_channels);
                            default:     w_ok = 1'b0;
                        endcase
                        if (!w_ok) begin
                            n_status = ST_ERROR;
                            n_err    = 1'b1;
                        end else if (w_cnt[4:2] == 3'(HEADER_WORDS)) begin
                            n_status = ST_HEADER_DONE;
                            n_phase  = (n_skip != '0) ? PH_SKIP : PH_DATA;
                        end else begin
                            n_status = ST_WORD_OK;
                        end
                    end
                end
                PH_SKIP: begin
                    n_status = ST_SKIPPING;
                    if (e_skip != '0) begin
                        n_skip = e_skip - 32'd1;
                    end
                    if (n_skip == '0) begin
                        n_phase = PH_DATA;
                    end
                end
                default: begin
                    if (!e_half) begin
                        n_high_byte = i_data_byte;
                        n_half      = 1'b1;
                        n_status    = ST_HALF_SAMPLE;
                    end else begin
                        n_samp   = {e_high, i_data_byte};
                        n_half   = 1'b0;
                        n_status = ST_SAMPLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic      <= RST_MAGIC;
            r_cfg_min_offset <= RST_MIN_OFFSET;
            r_cfg_encoding   <= RST_ENCODING;
            r_cfg_rate       <= RST_RATE;
            r_cfg_channels   <= RST_CHANNELS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAGIC:      r_cfg_magic      <= i_cfg_data;
                CFG_MIN_OFFSET: r_cfg_min_offset <= i_cfg_data;
                CFG_ENCODING:   r_cfg_encoding   <= i_cfg_data;
                CFG_RATE:       r_cfg_rate       <= i_cfg_data;
                CFG_CHANNELS:   r_cfg_channels   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_word_accum <= '0;
            r_skip       <= '0;
            r_phase      <= PH_HEADER;
            r_high_byte  <= '0;
            r_half       <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_byte_count <= n_byte_count;
                r_word_accum <= n_word_accum;
                r_skip       <= n_skip;
                r_phase      <= n_phase;
                r_high_byte  <= n_high_byte;
                r_half       <= n_half;
                r_err        <= n_err;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= n_status;
            r_widx   <= n_widx;
            r_wval   <= n_wval;
            r_samp   <= n_samp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_word_index   = r_widx;
    assign o_word_value   = r_wval;
    assign o_sample_value = r_samp;

endmodule

`default_nettype wire

// ===== design/au_hsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "au_header_and_sample_parser_top_defines.svh"

module au_hsp_checker (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  au_hsp_pkg::t_cfg_index   i_cfg_index,
    input  au_hsp_pkg::t_word        i_cfg_data,
    input  wire                      i_in_valid,
    input  wire                      o_in_ready,
    input  wire  [7:0]               i_data_byte,
    input  wire                      i_new_file,
    input  wire                      o_out_valid,
    input  wire                      i_out_ready,
    input  au_hsp_pkg::t_status      o_status,
    input  wire  [2:0]               o_word_index,
    input  au_hsp_pkg::t_word        o_word_value,
    input  wire signed [15:0]        o_sample_value
);
    import au_hsp_pkg::*;

    // No result survives reset.
    `AU_HSP_ASSERT_NEXT(a_reset_clears, !i_rst_n, !o_out_valid)

    // A waiting result that is not taken blocks the next byte.
    `AU_HSP_ASSERT_IMP(a_stall_blocks, o_out_valid && !i_out_ready, !o_in_ready)

    // A header word is reported only on word, done or error results.
    `AU_HSP_ASSERT_IMP(a_word_status, o_out_valid && o_word_index != 3'd0,
        o_status == ST_WORD_OK || o_status == ST_HEADER_DONE || o_status == ST_ERROR)

    // Header done always names the last header word.
    `AU_HSP_ASSERT_IMP(a_done_word, o_out_valid && o_status == ST_HEADER_DONE,
        o_word_index == WD_CHANNELS)

    // A held result keeps its status.
    `AU_HSP_ASSERT_NEXT(a_stall_holds, i_rst_n && o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status))

endmodule

bind au_header_and_sample_parser_top au_hsp_checker u_au_hsp_checker (.*);

`default_nettype wire
